// ----- sv/bdsl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdsl_pkg
// Shared types, constants and helpers of the blended duty slew limiter.
// ----------------------------------------------------------------------------
package bdsl_pkg;

  localparam int FRAC_BITS_DEF = 12;
  localparam int ADDR_W        = 5;
  localparam int DATA_W        = 32;
  localparam int IN_TDATA_W    = 40;
  localparam int OUT_TDATA_W   = 32;

  localparam logic [8:0] Q8_ONE = 9'd256;

  localparam logic [2:0] REG_THROTTLE_WEIGHT = 3'd0;
  localparam logic [2:0] REG_SMOOTH_ALPHA    = 3'd1;
  localparam logic [2:0] REG_MAX_STEP        = 3'd2;
  localparam logic [2:0] REG_SENSE_ENABLED   = 3'd3;
  localparam logic [2:0] REG_SENSE_ALPHA     = 3'd4;

  localparam logic [8:0] RST_THROTTLE_WEIGHT = 9'd218;
  localparam logic [8:0] RST_SMOOTH_ALPHA    = 9'd84;
  localparam logic [7:0] RST_MAX_STEP        = 8'd32;
  localparam logic       RST_SENSE_ENABLED   = 1'b1;
  localparam logic [8:0] RST_SENSE_ALPHA     = 9'd26;

  localparam logic [1:0] FUNC_UPDATE = 2'd0;
  localparam logic [1:0] FUNC_START  = 2'd1;
  localparam logic [1:0] FUNC_STOP   = 2'd2;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_WT   = 9'b000000010,
    ST_WP   = 9'b000000100,
    ST_AB   = 9'b000001000,
    ST_SCL  = 9'b000010000,
    ST_LAST = 9'b000100000,
    ST_SA   = 9'b001000000,
    ST_SB   = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_e;

  typedef struct packed {
    logic [8:0] weight;
    logic [8:0] alpha;
    logic [7:0] max_step;
    logic       sense_en;
    logic [8:0] sense_alpha;
  } cfg_t;

  typedef struct packed {
    state_e step;
    logic   capture;
    logic   out_load;
  } ctl_t;

  function automatic logic [8:0] sat_q8(input logic [8:0] v);
    return (v > Q8_ONE) ? Q8_ONE : v;
  endfunction

endpackage

// ----- sv/blended_duty_slew_limiter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blended_duty_slew_limiter
// Blends throttle and pressure into a smoothed, slew-limited PWM duty.
// ----------------------------------------------------------------------------
// Each item carries one command in tuser: update, start or stop. Start and stop
// go straight from idle to the done state; an update runs its products one after
// another through a single 9-bit by N-bit multiplier, stepping through WT, WP,
// AB, SCL and LAST, plus SA and SB with current sensing enabled, before done. In
// the done state the finished item waits for a full output register to drain and
// is then loaded into it. The input is ready again the cycle after the load, and
// is not ready while an item is in work; the output register lets the next item
// be taken while a result waits.
module blended_duty_slew_limiter #(
  parameter int FRAC_BITS = bdsl_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bdsl_pkg::ADDR_W-1:0]      paddr,
  input  logic [bdsl_pkg::DATA_W-1:0]      pwdata,
  output logic [bdsl_pkg::DATA_W-1:0]      prdata,
  output logic                             pready,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // throttle_level[12:0], pressure_level[25:13], sense_sample[37:26]
  input  logic [bdsl_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // func[1:0]
  input  logic [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // duty[7:0], enable_out[8], sense_filtered[28:9]
  output logic [bdsl_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import bdsl_pkg::*;

  cfg_t cfg;
  ctl_t ctl;
  logic out_free;

  bdsl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bdsl_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .func_i     (s_axis_tuser),
    .sense_en_i (cfg.sense_en),
    .out_free_i (out_free),
    .in_ready_o (s_axis_tready),
    .ctl_o      (ctl)
  );

  bdsl_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .cfg_i       (cfg),
    .func_i      (s_axis_tuser),
    .throttle_i  (s_axis_tdata[12:0]),
    .pressure_i  (s_axis_tdata[25:13]),
    .sample_i    (s_axis_tdata[37:26]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_free_o  (out_free)
  );

  a_one_item_in_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again while an item is in work");

  a_cmd_goes_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser != FUNC_UPDATE
    |=> ctl.step == ST_DONE)
    else $error("start or stop did not finish in one step");

  a_idle_duty_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[7:0] == 8'h00)
    else $error("duty driven while inactive");

  a_load_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwrote a pending item");

endmodule

// ----- sv/bdsl_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdsl_cfg
// Configuration register file with an APB-style write and read port.
// ----------------------------------------------------------------------------
module bdsl_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bdsl_pkg::ADDR_W-1:0]  paddr,
  input  logic [bdsl_pkg::DATA_W-1:0]  pwdata,
  output logic [bdsl_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output bdsl_pkg::cfg_t               cfg_o
);
  import bdsl_pkg::*;

  logic [8:0] weight_q, alpha_q, sense_alpha_q;
  logic [7:0] max_step_q;
  logic       sense_en_q;
  logic [2:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q      <= RST_THROTTLE_WEIGHT;
      alpha_q       <= RST_SMOOTH_ALPHA;
      max_step_q    <= RST_MAX_STEP;
      sense_en_q    <= RST_SENSE_ENABLED;
      sense_alpha_q <= RST_SENSE_ALPHA;
    end else if (wr) begin
      unique case (idx)
        REG_THROTTLE_WEIGHT: weight_q      <= pwdata[8:0];
        REG_SMOOTH_ALPHA:    alpha_q       <= pwdata[8:0];
        REG_MAX_STEP:        max_step_q    <= pwdata[7:0];
        REG_SENSE_ENABLED:   sense_en_q    <= pwdata[0];
        REG_SENSE_ALPHA:     sense_alpha_q <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_THROTTLE_WEIGHT: prdata = DATA_W'(weight_q);
      REG_SMOOTH_ALPHA:    prdata = DATA_W'(alpha_q);
      REG_MAX_STEP:        prdata = DATA_W'(max_step_q);
      REG_SENSE_ENABLED:   prdata = DATA_W'(sense_en_q);
      REG_SENSE_ALPHA:     prdata = DATA_W'(sense_alpha_q);
      default:             prdata = '0;
    endcase
  end

  assign cfg_o.weight      = sat_q8(weight_q);
  assign cfg_o.alpha       = sat_q8(alpha_q);
  assign cfg_o.max_step    = max_step_q;
  assign cfg_o.sense_en    = sense_en_q;
  assign cfg_o.sense_alpha = sat_q8(sense_alpha_q);

endmodule

// ----- sv/bdsl_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdsl_seq
// Step sequencer that walks the shared multiplier through one item.
// ----------------------------------------------------------------------------
module bdsl_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    func_i,
  input  logic          sense_en_i,
  input  logic          out_free_i,
  output logic          in_ready_o,
  output bdsl_pkg::ctl_t ctl_o
);
  import bdsl_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_ready_o & in_valid_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) state_d = (func_i == FUNC_UPDATE) ? ST_WT : ST_DONE;
      end
      ST_WT:   state_d = ST_WP;
      ST_WP:   state_d = ST_AB;
      ST_AB:   state_d = ST_SCL;
      ST_SCL:  state_d = ST_LAST;
      ST_LAST: state_d = sense_en_i ? ST_SA : ST_DONE;
      ST_SA:   state_d = ST_SB;
      ST_SB:   state_d = ST_DONE;
      ST_DONE: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign ctl_o.step     = state_q;
  assign ctl_o.capture  = accept;
  assign ctl_o.out_load = (state_q == ST_DONE) & out_free_i;

endmodule

// ----- sv/bdsl_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdsl_dp
// Datapath: shared multiplier, duty and sense state, output item register.
// ----------------------------------------------------------------------------
module bdsl_dp #(
  parameter int FRAC_BITS = bdsl_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bdsl_pkg::ctl_t                   ctl_i,
  input  bdsl_pkg::cfg_t                   cfg_i,
  input  logic [1:0]                       func_i,
  input  logic [12:0]                      throttle_i,
  input  logic [12:0]                      pressure_i,
  input  logic [11:0]                      sample_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [bdsl_pkg::OUT_TDATA_W-1:0] out_data_o,
  output logic                             out_free_o
);
  import bdsl_pkg::*;

  localparam int TW = (FRAC_BITS + 1 > 13) ? FRAC_BITS + 1 : 13;
  localparam int BW = (TW + 8 > 20) ? TW + 8 : 20;
  localparam int PW = BW + 9;
  localparam logic [TW-1:0] ONE = TW'(1) << FRAC_BITS;

  logic [TW-1:0]   t_q, p_q, t_raw, p_raw;
  logic [11:0]     samp_q;
  logic [PW-1:0]   tmp_q;
  logic [15:0]     z_q;
  logic [7:0]      last_q;
  logic            act_q;
  logic [19:0]     accum_q;
  logic            out_valid_q;
  logic [7:0]      duty_q;
  logic            en_q;
  logic [19:0]     sense_q;

  logic [8:0]      mul_a;
  logic [BW-1:0]   mul_b;
  logic [PW-1:0]   prod;
  logic [PW+7:0]   scaled;
  logic [16:0]     sum17;
  logic [8:0]      cand9;
  logic [8:0]      c9, last9, lim9, new9;
  logic [PW-1:0]   sense_sum;

  assign t_raw = TW'(throttle_i);
  assign p_raw = TW'(pressure_i);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctl_i.step)
      ST_WT: begin
        mul_a = cfg_i.weight;
        mul_b = BW'(t_q);
      end
      ST_WP: begin
        mul_a = Q8_ONE - cfg_i.weight;
        mul_b = BW'(p_q);
      end
      ST_AB: begin
        mul_a = cfg_i.alpha;
        mul_b = tmp_q[BW-1:0];
      end
      ST_LAST: begin
        mul_a = Q8_ONE - cfg_i.alpha;
        mul_b = BW'(last_q);
      end
      ST_SA: begin
        mul_a = Q8_ONE - cfg_i.sense_alpha;
        mul_b = BW'(accum_q);
      end
      ST_SB: begin
        mul_a = cfg_i.sense_alpha;
        mul_b = BW'({samp_q, 8'h00});
      end
      default: ;
    endcase
  end

  assign prod = PW'(mul_a) * PW'(mul_b);

  // times 255 as shift and subtract, then drop the blend fraction bits
  assign scaled = {tmp_q, 8'h00} - (PW + 8)'(tmp_q);

  assign sum17 = 17'(prod) + {1'b0, z_q};
  assign cand9 = sum17[16:8];
  assign c9    = (cand9 > 9'd255) ? 9'd255 : cand9;
  assign last9 = {1'b0, last_q};
  assign lim9  = {1'b0, cfg_i.max_step};

  always_comb begin
    new9 = c9;
    if (c9 > last9 && (c9 - last9) > lim9) new9 = last9 + lim9;
    if (c9 < last9 && (last9 - c9) > lim9) new9 = last9 - lim9;
  end

  assign sense_sum = tmp_q + prod;

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      t_q    <= (t_raw > ONE) ? ONE : t_raw;
      p_q    <= (p_raw > ONE) ? ONE : p_raw;
      samp_q <= sample_i;
    end
    unique case (ctl_i.step)
      ST_WT:   tmp_q <= prod;
      ST_WP:   tmp_q <= tmp_q + prod;
      ST_AB:   tmp_q <= prod;
      ST_SCL:  z_q   <= 16'(scaled >> (FRAC_BITS + 8));
      ST_SA:   tmp_q <= prod;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      act_q   <= 1'b0;
      accum_q <= '0;
    end else begin
      if (ctl_i.capture) begin
        if (func_i == FUNC_START) act_q <= 1'b1;
        if (func_i == FUNC_STOP)  act_q <= 1'b0;
      end
      if (ctl_i.step == ST_LAST) last_q  <= new9[7:0];
      if (ctl_i.step == ST_SB)   accum_q <= 20'(sense_sum >> 8);
    end
  end

  assign out_free_o = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      duty_q  <= act_q ? last_q : 8'h00;
      en_q    <= act_q;
      sense_q <= accum_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {3'b000, sense_q, en_q, duty_q};

endmodule
